@@ src/ddd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types and constants for the digest dedup dictionary.
// ----------------------------------------------------------------------------
package ddd_pkg;

  localparam int DIGEST_W      = 256;
  localparam int FIELD_W       = 64;
  localparam int INDEX_W       = 10;
  localparam int COUNT_W       = 11;
  localparam int STATUS_W      = 2;
  localparam int HASH_BITS_DEF = 8;
  localparam int WAYS_DEF      = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  // One way of a bucket row
  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] idx;
    logic [DIGEST_W-1:0] dig;
  } way_t;

  // Table access request from the controller
  typedef struct packed {
    logic rd;
    logic wr;
  } tbl_req_t;

endpackage
`default_nettype wire

@@ src/ddd_fold.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_fold
// XOR fold of a 256-bit digest to a bucket number: digest bit k feeds
// hash bit k mod HASH_BITS.
// ----------------------------------------------------------------------------
module ddd_fold #(
  parameter int HASH_BITS = ddd_pkg::HASH_BITS_DEF
) (
  input  wire logic [ddd_pkg::DIGEST_W-1:0] digest,
  output logic      [HASH_BITS-1:0]         hash
);
  import ddd_pkg::*;

  always_comb begin
    hash = '0;
    for (int k = 0; k < DIGEST_W; k++) begin
      hash[k % HASH_BITS] = hash[k % HASH_BITS] ^ digest[k];
    end
  end

endmodule
`default_nettype wire

@@ src/ddd_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_table
// Bucket memory: one row per bucket holding all ways (valid, index, digest).
// Single port, registered read. Sweeps every row to zero after reset.
// ----------------------------------------------------------------------------
module ddd_table #(
  parameter int HASH_BITS = ddd_pkg::HASH_BITS_DEF,
  parameter int WAYS      = ddd_pkg::WAYS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ddd_pkg::tbl_req_t     req,
  input  wire logic [HASH_BITS-1:0]  addr,
  input  wire ddd_pkg::way_t [WAYS-1:0] wr_row,
  output ddd_pkg::way_t [WAYS-1:0]   rd_row,
  output logic                       busy
);
  import ddd_pkg::*;

  localparam int NUM_ROWS = 1 << HASH_BITS;

  way_t [WAYS-1:0] mem [NUM_ROWS];
  way_t [WAYS-1:0] rd_row_r;

  logic [HASH_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                 clr_busy_r, clr_busy_nxt;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == {HASH_BITS{1'b1}}) clr_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.wr) begin
      mem[addr] <= wr_row;
    end
    if (req.rd) rd_row_r <= mem[addr];
  end

  assign rd_row = rd_row_r;
  assign busy   = clr_busy_r;

endmodule
`default_nettype wire

@@ src/digest_dedup_dictionary.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// digest_dedup_dictionary
// Set-associative dictionary of chunk digests with lookup and insert.
// ----------------------------------------------------------------------------
// Each digest first has its bucket row read from the single-port table; then
// all ways are compared and the row is written back on an insert. One
// digest is in flight at a time, so a following digest always sees the row
// as left by the previous one. After reset the table is swept clear, one row
// a cycle, before in_ready rises. A result is held in an output register;
// the lookup stage waits only if a previous result has not yet been taken.
module digest_dedup_dictionary #(
  parameter int HASH_BITS = ddd_pkg::HASH_BITS_DEF,
  parameter int WAYS      = ddd_pkg::WAYS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ddd_pkg::FIELD_W-1:0]   in_digest_bits_0_63,
  input  wire logic [ddd_pkg::FIELD_W-1:0]   in_digest_bits_64_127,
  input  wire logic [ddd_pkg::FIELD_W-1:0]   in_digest_bits_128_191,
  input  wire logic [ddd_pkg::FIELD_W-1:0]   in_digest_bits_192_255,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [ddd_pkg::STATUS_W-1:0]  out_lookup_status,
  output logic      [ddd_pkg::INDEX_W-1:0]   out_chunk_index
);
  import ddd_pkg::*;

  state_t state_r, state_nxt;

  logic [DIGEST_W-1:0]  in_digest;
  logic [DIGEST_W-1:0]  digest_r;
  logic [HASH_BITS-1:0] hash;
  logic [HASH_BITS-1:0] bucket_r;
  logic [COUNT_W-1:0]   next_index_r, next_index_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r;
  logic [INDEX_W-1:0]   out_index_r;

  tbl_req_t             req;
  logic [HASH_BITS-1:0] tbl_addr;
  way_t [WAYS-1:0]      rd_row;
  way_t [WAYS-1:0]      wr_row;
  logic                 tbl_busy;

  logic                 hit_any, free_any;
  logic [INDEX_W-1:0]   hit_idx;
  logic [WAYS-1:0]      free_sel;
  logic                 accept, finish;
  status_t              res_status;
  logic [INDEX_W-1:0]   res_index;
  way_t                 new_way;

  assign in_digest = {in_digest_bits_192_255, in_digest_bits_128_191,
                      in_digest_bits_64_127, in_digest_bits_0_63};

  ddd_fold #(.HASH_BITS(HASH_BITS)) u_fold (
    .digest (in_digest),
    .hash   (hash)
  );

  ddd_table #(.HASH_BITS(HASH_BITS), .WAYS(WAYS)) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .addr   (tbl_addr),
    .wr_row (wr_row),
    .rd_row (rd_row),
    .busy   (tbl_busy)
  );

  // Way compare; lowest-numbered hit and lowest-numbered free way win
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_sel = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row[w].valid && (rd_row[w].dig == digest_r)) begin
        hit_any = 1'b1;
        hit_idx = rd_row[w].idx;
      end
      if (!rd_row[w].valid) begin
        free_any    = 1'b1;
        free_sel    = '0;
        free_sel[w] = 1'b1;
      end
    end
  end

  always_comb begin
    new_way.valid = 1'b1;
    new_way.idx   = next_index_r[INDEX_W-1:0];
    new_way.dig   = digest_r;
    for (int w = 0; w < WAYS; w++) begin
      wr_row[w] = free_sel[w] ? new_way : rd_row[w];
    end
  end

  always_comb begin
    if (hit_any) begin
      res_status = ST_FOUND;
      res_index  = hit_idx;
    end else if (free_any) begin
      res_status = ST_INSERTED;
      res_index  = next_index_r[INDEX_W-1:0];
    end else begin
      res_status = ST_FULL;
      res_index  = '0;
    end
  end

  assign accept = (state_r == S_IDLE) && !tbl_busy && in_valid;
  assign finish = (state_r == S_LOOKUP) && (!out_valid_r || out_ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_LOOKUP;
      S_LOOKUP: if (finish) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_ready = 1'b0;
    req      = '0;
    tbl_addr = bucket_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = !tbl_busy;
        req.rd   = accept;
        tbl_addr = hash;
      end
      S_LOOKUP: begin
        req.wr = finish && !hit_any && free_any;
      end
      default: ;
    endcase
  end

  always_comb begin
    next_index_nxt = next_index_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (finish) begin
      out_valid_nxt = 1'b1;
      if (res_status == ST_INSERTED) next_index_nxt = next_index_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      next_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_index_r <= next_index_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      digest_r <= in_digest;
      bucket_r <= hash;
    end
    if (finish) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_lookup_status = out_status_r;
  assign out_chunk_index   = out_index_r;

endmodule
`default_nettype wire

@@ src/ddd_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_check
// Port-level checks for the digest dedup dictionary, bound to the top level.
// ----------------------------------------------------------------------------
module ddd_check (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ddd_pkg::STATUS_W-1:0]  out_lookup_status,
  input wire logic [ddd_pkg::INDEX_W-1:0]   out_chunk_index
);
  import ddd_pkg::*;

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lookup_status)
      && $stable(out_chunk_index))
    else $error("result changed while stalled");

  // Only one digest in flight
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken during lookup");

  // A result is pending after every accepted digest
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result after lookup");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_lookup_status == ST_FULL) |-> out_chunk_index == '0)
    else $error("full bucket reported a non-zero index");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lookup_status == ST_FOUND) || (out_lookup_status == ST_INSERTED)
      || (out_lookup_status == ST_FULL))
    else $error("undefined status code");

endmodule

bind digest_dedup_dictionary ddd_check u_ddd_check (.*);
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the digest dedup dictionary. Digests are sent over
// the input channel while a scoreboard of the bucket table predicts each
// lookup outcome (found, inserted, bucket full) and the chunk index returned.
// ----------------------------------------------------------------------------
module testbench;
  import ddd_pkg::*;

  localparam int HB          = HASH_BITS_DEF;
  localparam int NWAYS       = WAYS_DEF;
  localparam int NUM_ENTRIES = (1 << HB) * NWAYS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 425;

  typedef struct {
    status_t            status;
    logic [INDEX_W-1:0] idx;
  } lookup_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FIELD_W-1:0]  in_digest_bits_0_63 = '0;
  logic [FIELD_W-1:0]  in_digest_bits_64_127 = '0;
  logic [FIELD_W-1:0]  in_digest_bits_128_191 = '0;
  logic [FIELD_W-1:0]  in_digest_bits_192_255 = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_lookup_status;
  logic [INDEX_W-1:0]  out_chunk_index;

  // Scoreboard copy of the dictionary
  logic [DIGEST_W-1:0] stored_digest [NUM_ENTRIES];
  logic [INDEX_W-1:0]  stored_index [NUM_ENTRIES];
  bit                  stored_valid [NUM_ENTRIES];
  logic [COUNT_W-1:0]  running_index = '0;

  lookup_t             pending_lookups[$];
  logic [DIGEST_W-1:0] sent_digests[$];
  int                  errors = 0;
  int                  cycle_count = 0;
  int                  wait_left = 0;
  bit                  no_gaps = 1'b0;

  digest_dedup_dictionary #(
    .HASH_BITS(HB),
    .WAYS     (NWAYS)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_digest_bits_0_63   (in_digest_bits_0_63),
    .in_digest_bits_64_127 (in_digest_bits_64_127),
    .in_digest_bits_128_191(in_digest_bits_128_191),
    .in_digest_bits_192_255(in_digest_bits_192_255),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_lookup_status     (out_lookup_status),
    .out_chunk_index       (out_chunk_index)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Digest bit k toggles bucket bit k mod HB
  function automatic logic [HB-1:0] fold_to_bucket(input logic [DIGEST_W-1:0] d);
    logic [HB-1:0] h;
    h = '0;
    for (int k = 0; k < DIGEST_W; k++) begin
      h[k % HB] = h[k % HB] ^ d[k];
    end
    return h;
  endfunction

  function automatic lookup_t dictionary_lookup(input logic [DIGEST_W-1:0] d);
    lookup_t r;
    int      base;
    int      free_way;
    int      e;
    base     = int'(fold_to_bucket(d)) * NWAYS;
    free_way = -1;
    for (int w = 0; w < NWAYS; w++) begin
      e = base + w;
      if (stored_valid[e]) begin
        if (stored_digest[e] == d) begin
          r.status = ST_FOUND;
          r.idx    = stored_index[e];
          return r;
        end
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (free_way < 0) begin
      r.status = ST_FULL;
      r.idx    = '0;
      return r;
    end
    e                = base + free_way;
    stored_digest[e] = d;
    stored_index[e]  = running_index[INDEX_W-1:0];
    stored_valid[e]  = 1'b1;
    r.status         = ST_INSERTED;
    r.idx            = running_index[INDEX_W-1:0];
    running_index    = running_index + 1'b1;
    return r;
  endfunction

  function automatic logic [DIGEST_W-1:0] random_digest();
    logic [DIGEST_W-1:0] d;
    logic [DIGEST_W-1:0] m;
    for (int i = 0; i < DIGEST_W / 32; i++) begin
      d[32*i +: 32] = $urandom;
      m[32*i +: 32] = $urandom;
    end
    case ($urandom_range(0, 3))
      0:       d = d & m;
      1:       d = d | m;
      default: ;
    endcase
    return d;
  endfunction

  // Low field bits map one to one onto bucket bits, so patch them to land
  function automatic logic [DIGEST_W-1:0] aim_at_bucket(input logic [DIGEST_W-1:0] d,
                                                        input logic [HB-1:0] bucket);
    logic [DIGEST_W-1:0] r;
    r         = d;
    r[HB-1:0] = r[HB-1:0] ^ fold_to_bucket(d) ^ bucket;
    return r;
  endfunction

  // Two flips HB apart leave the bucket unchanged
  function automatic logic [DIGEST_W-1:0] near_duplicate(input logic [DIGEST_W-1:0] d);
    logic [DIGEST_W-1:0] r;
    int unsigned         k;
    r      = d;
    k      = $urandom_range(0, DIGEST_W - HB - 1);
    r[k]   = ~r[k];
    r[k+HB] = ~r[k+HB];
    return r;
  endfunction

  task automatic send_digest(input logic [DIGEST_W-1:0] d);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_digest_bits_0_63    <= d[63:0];
    in_digest_bits_64_127  <= d[127:64];
    in_digest_bits_128_191 <= d[191:128];
    in_digest_bits_192_255 <= d[255:192];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_lookups.push_back(dictionary_lookup(d));
    sent_digests.push_back(d);
  endtask

  // All of these fold to bucket zero, so the bucket fills and then overflows
  task automatic test_field_extremes();
    send_digest('0);
    send_digest('1);
    send_digest({{3*FIELD_W{1'b0}}, {FIELD_W{1'b1}}});
    send_digest({{FIELD_W{1'b1}}, {3*FIELD_W{1'b0}}});
    send_digest('0);
    send_digest('1);
    send_digest({(DIGEST_W/2){2'b01}});
    send_digest({(DIGEST_W/2){2'b10}});
  endtask

  task automatic test_bucket_overflow();
    logic [HB-1:0]       target;
    logic [DIGEST_W-1:0] first;
    logic [DIGEST_W-1:0] rejected;
    target = HB'($urandom_range(1, (1 << HB) - 1));
    first  = aim_at_bucket(random_digest(), target);
    send_digest(first);
    for (int i = 0; i < NWAYS + 1; i++) begin
      rejected = aim_at_bucket(random_digest(), target);
      send_digest(rejected);
    end
    send_digest(first);
    send_digest(rejected);
    send_digest(near_duplicate(first));
  endtask

  // A single set bit lands in the bucket named by its position within the byte
  task automatic test_hash_bit_positions();
    logic [DIGEST_W-1:0] d;
    for (int j = 0; j < HB; j++) begin
      d = '0;
      d[FIELD_W * (j % 4) + 8 * $urandom_range(0, 7) + j] = 1'b1;
      send_digest(d);
    end
  endtask

  task automatic test_random_traffic();
    logic [HB-1:0]       hot [5];
    logic [DIGEST_W-1:0] d;
    int unsigned         pick;
    foreach (hot[i]) hot[i] = HB'($urandom_range(0, (1 << HB) - 1));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        d = random_digest();
      end else if (pick < 65) begin
        d = sent_digests[$urandom_range(0, sent_digests.size() - 1)];
      end else if (pick < 90) begin
        d = aim_at_bucket(random_digest(), hot[$urandom_range(0, 4)]);
      end else begin
        d = near_duplicate(sent_digests[$urandom_range(0, sent_digests.size() - 1)]);
      end
      send_digest(d);
    end
    no_gaps = 1'b0;
  endtask

  // Result side: check each transaction, then draw a stall before the next one
  always @(posedge clk) begin : result_monitor
    lookup_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result, status %0d index %0d", $time,
                 out_lookup_status, out_chunk_index);
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        if (out_lookup_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status,
                   out_lookup_status);
          errors++;
        end
        if (out_chunk_index !== want.idx) begin
          $display("%0t: chunk index expected %0d got %0d", $time, want.idx,
                   out_chunk_index);
          errors++;
        end
      end
      wait_left = no_gaps ? 0 : $urandom_range(0, 7);
    end
    if (wait_left > 0) begin
      wait_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_bucket_overflow();
    test_hash_bit_positions();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ddd_pkg.sv
src/ddd_fold.sv
src/ddd_table.sv
src/digest_dedup_dictionary.sv
src/ddd_check.sv
tb/sv/testbench.sv
